// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

    // Field widths of the config, item and result ports
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 11;
    localparam int FILL_W   = 11;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes
    localparam op_t OP_PUSH  = 2'd0;
    localparam op_t OP_POP   = 2'd1;
    localparam op_t OP_STEAL = 2'd2;

    // Result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== hdl/work_stealing_deque_core.sv =====
// Push, an unknown op and a pop or steal on an empty deque: the result is valid in the
// cycle after item accept; such items can be accepted every cycle while the result is not stalled.
// Pop and steal that take a word: the slot memory is read (registered read port) while
// pend_reg is set; the next item is accepted once the read data has been captured.
// A result waits in an output register; a new item is taken while it is consumed.
// Reset (rst_n low, asynchronous) empties the deque and sets capacity to
// min(1024, DEPTH); slot contents are not cleared.
module work_stealing_deque_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsd_pkg::CAP_W-1:0]     capacity_in_use,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wsd_pkg::OP_W-1:0]      op,
    input  logic [wsd_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wsd_pkg::STATUS_W-1:0]  status,
    output logic [wsd_pkg::VALUE_W-1:0]   taken,
    output logic [wsd_pkg::FILL_W-1:0]    fill
);

    import wsd_pkg::*;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int EW        = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
    localparam int RESET_CAP = (DEPTH < 1024) ? DEPTH : 1024;

    logic [PTR_W-1:0]      top_reg, top_next;
    logic [PTR_W-1:0]      bot_reg, bot_next;
    logic [FILL_W-1:0]     count_reg, count_next;
    logic [EW-1:0]         cap_reg, cap_next;
    logic                  pend_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [DATA_WIDTH-1:0] taken_reg;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  is_full;
    logic                  is_empty;
    logic [PTR_W-1:0]      top_inc;
    logic [PTR_W-1:0]      bot_inc;
    logic [PTR_W-1:0]      bot_dec;
    logic [EW-1:0]         cap_wr;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  rd_start;
    status_t               st;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign in_stall  = pend_reg | (out_valid_reg & out_stall);
    assign in_acc    = in_valid & ~in_stall;

    // Occupancy and wrapping pointer steps
    assign is_full  = EW'(count_reg) >= cap_reg;
    assign is_empty = (count_reg == '0);
    assign top_inc  = (EW'(top_reg) + EW'(1) >= cap_reg) ? '0 : top_reg + PTR_W'(1);
    assign bot_inc  = (EW'(bot_reg) + EW'(1) >= cap_reg) ? '0 : bot_reg + PTR_W'(1);
    assign bot_dec  = (bot_reg == '0) ? PTR_W'(cap_reg - EW'(1)) : bot_reg - PTR_W'(1);

    // Clamp a written capacity into 1..DEPTH
    always_comb
    begin
        cap_wr = EW'(capacity_in_use);
        if (cap_wr == '0)
        begin
            cap_wr = EW'(1);
        end
        else if (cap_wr > EW'(DEPTH))
        begin
            cap_wr = EW'(DEPTH);
        end
    end

    // Decode the item, pick the slot and update pointers and count
    always_comb
    begin
        top_next   = top_reg;
        bot_next   = bot_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        ram_we     = 1'b0;
        ram_raddr  = top_reg;
        rd_start   = 1'b0;
        st         = ST_DONE;
        if (cfg_acc)
        begin
            cap_next   = cap_wr;
            top_next   = '0;
            bot_next   = '0;
            count_next = '0;
        end
        else if (in_acc)
        begin
            unique case (op)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        bot_next   = bot_inc;
                        count_next = count_reg + FILL_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        ram_raddr  = bot_dec;
                        rd_start   = 1'b1;
                        bot_next   = bot_dec;
                        count_next = count_reg - FILL_W'(1);
                    end
                end
                OP_STEAL:
                begin
                    if (is_empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        ram_raddr  = top_reg;
                        rd_start   = 1'b1;
                        top_next   = top_inc;
                        count_next = count_reg - FILL_W'(1);
                    end
                end
                default:
                begin
                    st = ST_DONE;
                end
            endcase
        end
    end

    // Slot memory
    wsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bot_reg),
        .wdata (value[DATA_WIDTH-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            bot_reg       <= '0;
            count_reg     <= '0;
            cap_reg       <= EW'(RESET_CAP);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            if (in_acc)
            begin
                pend_reg      <= rd_start;
                out_valid_reg <= ~rd_start;
            end
            else if (pend_reg)
            begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg & ~out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, fill in read data in the cycle after
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg <= st;
            fill_reg   <= count_next;
            taken_reg  <= '0;
        end
        else if (pend_reg)
        begin
            taken_reg <= ram_rdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign taken     = VALUE_W'(taken_reg);
    assign fill      = fill_reg;

endmodule

// ===== hdl/wsd_ram.sv =====
module wsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/wsd_checker.sv =====
module wsd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [wsd_pkg::STATUS_W-1:0]  status,
    input logic [wsd_pkg::VALUE_W-1:0]   taken,
    input logic [wsd_pkg::FILL_W-1:0]    fill
);

    import wsd_pkg::*;

    // Empty report leaves nothing held
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill == '0)
        else $error("empty status with nonzero fill");

    // Full report means something is held
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> fill != '0)
        else $error("full status with zero fill");

    // Failed operations return no word
    a_fail_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_EMPTY) |-> taken == '0)
        else $error("failed operation returned a word");

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(status) && $stable(taken) && $stable(fill))
        else $error("stalled result changed");

endmodule

bind work_stealing_deque_core wsd_checker u_wsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .taken     (taken),
    .fill      (fill)
);
